### hw/rtl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Types and constants shared by the nearest point correspondence block.
// ----------------------------------------------------------------------------
package npc_pkg;

   localparam int unsigned TARGET_COUNT_W      = 11;
   localparam int unsigned INDEX_W             = 16;
   localparam int unsigned COORD_W             = 16;
   localparam int unsigned NEAREST_W           = 10;
   localparam int unsigned DIST_W              = 33;
   localparam int unsigned DEFAULT_MAX_TARGETS = 1024;
   localparam int unsigned CMD_QUEUE_DEPTH     = 4;
   localparam int unsigned CMD_QUEUE_AW        = $clog2(CMD_QUEUE_DEPTH);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [INDEX_W-1:0]         point_index;
      logic signed [COORD_W-1:0]  point_x;
      logic signed [COORD_W-1:0]  point_y;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]   source_number;
      logic [NEAREST_W-1:0] nearest_index;
      logic [DIST_W-1:0]    nearest_dist_sq;
   } rsp_type;

   // A classified item as it waits between the front and the back.
   typedef struct packed {
      op_type                     op;
      logic                       slot_ok;
      logic [INDEX_W-1:0]         point_index;
      logic signed [COORD_W-1:0]  point_x;
      logic signed [COORD_W-1:0]  point_y;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } back_state_type;

endpackage

### hw/rtl/nearest_point_correspondence_top.sv
// ----------------------------------------------------------------------------
// nearest_point_correspondence_top
// Brute-force 2-D nearest target search over a loadable store of points.
// ----------------------------------------------------------------------------
// A load writes one target point into the store if its slot lies inside the
// store. A query scans target slots 0 to min(target_count, MAX_TARGETS)-1, one
// per cycle through the single registered read port of the target store and
// on through the distance pipeline. Items are queued in front of the back end
// (four deep) and one finished result is held on the output, so transfers on
// either side continue while a query is being worked on. The store has no
// reset: every slot that a query scans must have been loaded.
module nearest_point_correspondence_top #(
   parameter int unsigned MAX_TARGETS = npc_pkg::DEFAULT_MAX_TARGETS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  npc_pkg::req_type                    req_data,
   output logic                                empty,
   input  logic                                pop,
   output npc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [npc_pkg::TARGET_COUNT_W-1:0]  csr_wdata
);
   import npc_pkg::*;

   cmd_link_type cmd_link;
   logic         cmd_pop;

   npc_front #(
      .MAX_TARGETS (MAX_TARGETS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_link (cmd_link),
      .cmd_pop  (cmd_pop)
   );

   npc_back #(
      .MAX_TARGETS (MAX_TARGETS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .cmd_link  (cmd_link),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/npc_front.sv
// ----------------------------------------------------------------------------
// npc_front
// Accepts items, marks loads whose slot lies outside the store, and holds
// them in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module npc_front #(
   parameter int unsigned MAX_TARGETS = npc_pkg::DEFAULT_MAX_TARGETS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  npc_pkg::req_type      req_data,
   output npc_pkg::cmd_link_type cmd_link,
   input  logic                  cmd_pop
);
   import npc_pkg::*;

   localparam int unsigned SLOT_CMP_W = INDEX_W + 1;

   cmd_type                 queue_ff [CMD_QUEUE_DEPTH];
   logic [CMD_QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_QUEUE_AW:0]   cnt_ff, cnt_in;
   logic                    push_ok;
   logic                    pop_ok;
   cmd_type                 cmd_new;

   always_comb begin
      cmd_new.op          = req_data.op;
      cmd_new.slot_ok     = {1'b0, req_data.point_index} < SLOT_CMP_W'(MAX_TARGETS);
      cmd_new.point_index = req_data.point_index;
      cmd_new.point_x     = req_data.point_x;
      cmd_new.point_y     = req_data.point_y;
   end

   assign full    = (cnt_ff == (CMD_QUEUE_AW + 1)'(CMD_QUEUE_DEPTH));
   assign push_ok = push && !full;
   assign pop_ok  = cmd_pop && (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + CMD_QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + CMD_QUEUE_AW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + (CMD_QUEUE_AW + 1)'(push_ok) - (CMD_QUEUE_AW + 1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_link.valid = (cnt_ff != '0);
   assign cmd_link.cmd   = queue_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   a_cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (CMD_QUEUE_AW + 1)'(CMD_QUEUE_DEPTH))
      else $error("command queue count exceeds its depth");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !pop_ok) |=> (cnt_ff == $past(cnt_ff) + (CMD_QUEUE_AW + 1)'(1)))
      else $error("accepted transfer not counted in the command queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (cnt_ff != '0))
      else $error("back end took a command from an empty queue");
`endif

endmodule

### hw/rtl/npc_back.sv
// ----------------------------------------------------------------------------
// npc_back
// Executes queued commands: loads write the target store, queries scan it
// through the distance pipeline and keep the first minimum.
// ----------------------------------------------------------------------------
module npc_back #(
   parameter int unsigned MAX_TARGETS = npc_pkg::DEFAULT_MAX_TARGETS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [npc_pkg::TARGET_COUNT_W-1:0]   csr_wdata,
   input  npc_pkg::cmd_link_type                cmd_link,
   output logic                                 cmd_pop,
   output logic                                 empty,
   input  logic                                 pop,
   output npc_pkg::rsp_type                     rsp_data
);
   import npc_pkg::*;

   localparam int unsigned AW   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam int unsigned CW   = (AW + 1 > TARGET_COUNT_W) ? AW + 1 : TARGET_COUNT_W;
   localparam int unsigned IW   = (AW > NEAREST_W) ? AW : NEAREST_W;
   localparam int unsigned SQ_W = 2 * COORD_W;

   logic [2*COORD_W-1:0]         store_mem [MAX_TARGETS];

   back_state_type               state_ff, state_in;
   logic [TARGET_COUNT_W-1:0]    target_count_ff;
   logic [CW-1:0]                count_ff, count_in, count_clamped;
   logic [AW-1:0]                scan_cnt_ff, scan_cnt_in;
   cmd_type                      src_ff, src_in;
   logic                         mem_we;
   logic                         issue;
   logic                         last_issue;
   logic                         best_start;
   logic                         load_rsp;

   logic                         p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   logic                         p1_last_ff, p2_last_ff, p3_last_ff, p4_last_ff;
   logic [AW-1:0]                p1_idx_ff, p2_idx_ff, p3_idx_ff, p4_idx_ff;
   logic [2*COORD_W-1:0]         rd_data_ff;
   logic [COORD_W:0]             diff_x, diff_y;
   logic [COORD_W-1:0]           dx_in, dy_in, dx_ff, dy_ff;
   logic [SQ_W-1:0]              sqx_ff, sqy_ff;
   logic [DIST_W-1:0]            dist_ff;
   logic [IW-1:0]                idx_wide;

   logic [DIST_W-1:0]            best_dist_ff, best_dist_in;
   logic [NEAREST_W-1:0]         best_idx_ff, best_idx_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_count_ff <= '0;
      end else if (csr_valid) begin
         target_count_ff <= csr_wdata;
      end
   end

   assign count_clamped = (CW'(target_count_ff) > CW'(MAX_TARGETS)) ?
                          CW'(MAX_TARGETS) : CW'(target_count_ff);
   assign last_issue    = (CW'(scan_cnt_ff) == count_ff - CW'(1));

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_cnt_in = scan_cnt_ff;
      src_in      = src_ff;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      issue       = 1'b0;
      best_start  = 1'b0;
      load_rsp    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_link.valid) begin
               cmd_pop = 1'b1;
               if (cmd_link.cmd.op == OP_LOAD) begin
                  mem_we = cmd_link.cmd.slot_ok;
               end else begin
                  src_in      = cmd_link.cmd;
                  count_in    = count_clamped;
                  scan_cnt_in = '0;
                  best_start  = 1'b1;
                  state_in    = (count_clamped == '0) ? ST_FINISH : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            issue       = 1'b1;
            scan_cnt_in = scan_cnt_ff + AW'(1);
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (p4_valid_ff && p4_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || pop) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      scan_cnt_ff <= scan_cnt_in;
      src_ff      <= src_in;
   end

   // Target store: one write port for loads, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[cmd_link.cmd.point_index[AW-1:0]] <=
            {cmd_link.cmd.point_y, cmd_link.cmd.point_x};
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[scan_cnt_ff];
   end

   // Absolute differences fit in 16 bits, so each square fits in 32.
   always_comb begin
      diff_x = {rd_data_ff[COORD_W-1], rd_data_ff[COORD_W-1:0]}
             - {src_ff.point_x[COORD_W-1], src_ff.point_x};
      diff_y = {rd_data_ff[2*COORD_W-1], rd_data_ff[2*COORD_W-1:COORD_W]}
             - {src_ff.point_y[COORD_W-1], src_ff.point_y};
      dx_in  = diff_x[COORD_W] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
      dy_in  = diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= issue;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_last_ff <= last_issue;
      p1_idx_ff  <= scan_cnt_ff;
      p2_last_ff <= p1_last_ff;
      p2_idx_ff  <= p1_idx_ff;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      p3_last_ff <= p2_last_ff;
      p3_idx_ff  <= p2_idx_ff;
      sqx_ff     <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sqy_ff     <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
      p4_last_ff <= p3_last_ff;
      p4_idx_ff  <= p3_idx_ff;
      dist_ff    <= DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
   end

   assign idx_wide = IW'(p4_idx_ff);

   // The start value is all ones and above any real distance, so the first
   // target always replaces it; strict less-than keeps the first minimum.
   always_comb begin
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (best_start) begin
         best_dist_in = '1;
         best_idx_in  = '0;
      end else if (p4_valid_ff && (dist_ff < best_dist_ff)) begin
         best_dist_in = dist_ff;
         best_idx_in  = idx_wide[NEAREST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff.source_number   <= src_ff.point_index;
         rsp_ff.nearest_index   <= best_idx_ff;
         rsp_ff.nearest_dist_sq <= best_dist_ff;
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef ASSERT_OFF
   a_rsp_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !pop) |=> rsp_valid_ff)
      else $error("waiting result dropped without a transfer");

   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      p4_valid_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance pipeline active outside a query scan");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CW'(scan_cnt_ff) < count_ff))
      else $error("scan address beyond the configured target count");
`endif

endmodule
